### src/sasc_pkg.sv
// shared constants and types for the strand-aware interval set compare block
package sasc_pkg;

   // fixed width of every coordinate port and of the csr data
   localparam int FIELD_WIDTH = 40;

   // default internal coordinate width
   localparam int COORD_WIDTH_DEFAULT = 40;

   // control for one accumulate step
   typedef struct packed {
      logic take;          // stage 2 item moves on this cycle
      logic fin;           // item closes the comparison
      logic shared;        // taxon present in both seeds
      logic this_earlier;  // mapped start of this seed below the other
   } step_type;

endpackage

### src/sasc_fwd_map.sv
// maps one interval to forward-strand coordinates and sorts it
module sasc_fwd_map #(
   parameter int COORD_WIDTH = 40
) (
   input  logic [COORD_WIDTH-1:0] first,
   input  logic [COORD_WIDTH-1:0] last,
   input  logic [COORD_WIDTH-1:0] rev_start,
   output logic                   present,
   output logic [COORD_WIDTH-1:0] start,
   output logic [COORD_WIDTH-1:0] lo,
   output logic [COORD_WIDTH-1:0] hi
);

   logic                   is_rev;
   logic [COORD_WIDTH-1:0] map_first;
   logic [COORD_WIDTH-1:0] map_last;

   assign present = (first != '1) && (last >= first);

   // reverse-strand decision is taken on the start coordinate only
   assign is_rev    = (first >= rev_start);
   assign map_first = is_rev ? (rev_start + rev_start - first) : first;
   assign map_last  = is_rev ? (rev_start + rev_start - last)  : last;

   assign start = map_first;
   assign lo    = (map_first < map_last) ? map_first : map_last;
   assign hi    = (map_first < map_last) ? map_last  : map_first;

endmodule

### src/sasc_accum.sv
// overlap, order and gap accumulators plus the result register
module sasc_accum #(
   parameter int COORD_WIDTH = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sasc_pkg::step_type     step,
   input  logic [COORD_WIDTH-1:0] this_lo,
   input  logic [COORD_WIDTH-1:0] this_hi,
   input  logic [COORD_WIDTH-1:0] other_lo,
   input  logic [COORD_WIDTH-1:0] other_hi,
   input  logic                   rsp_stall,
   output logic                   out_free,
   output logic                   rsp_valid,
   output logic                   rsp_overlaps,
   output logic                   rsp_order_consistent,
   output logic [COORD_WIDTH-1:0] rsp_gap
);
   import sasc_pkg::*;

   logic                   order_known_ff, order_known_in;
   logic                   this_before_ff, this_before_in;
   logic                   overlap_ff, overlap_in;
   logic                   broken_ff, broken_in;
   logic [COORD_WIDTH-1:0] max_gap_ff, max_gap_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_overlaps_ff;
   logic                   rsp_consistent_ff;
   logic [COORD_WIDTH-1:0] rsp_gap_ff;

   logic                   pair_overlap;
   logic [COORD_WIDTH-1:0] gap;
   logic                   upd_known, upd_before, upd_overlap, upd_broken;
   logic [COORD_WIDTH-1:0] upd_max;

   assign pair_overlap = (this_lo <= other_hi) && (other_lo <= this_hi);

   always_comb begin
      priority if (this_lo > other_hi) begin
         gap = this_lo - other_hi;
      end else if (other_lo > this_hi) begin
         gap = other_lo - this_hi;
      end else begin
         gap = '0;
      end
   end

   // state after this item, before any end-of-comparison clear
   always_comb begin
      upd_known   = order_known_ff;
      upd_before  = this_before_ff;
      upd_overlap = overlap_ff;
      upd_broken  = broken_ff;
      upd_max     = max_gap_ff;
      if (step.shared) begin
         if (pair_overlap) begin
            upd_overlap = 1'b1;
         end
         if (!order_known_ff) begin
            upd_known  = 1'b1;
            upd_before = step.this_earlier;
         end else if (step.this_earlier != this_before_ff) begin
            upd_broken = 1'b1;
         end
         if (gap > max_gap_ff) begin
            upd_max = gap;
         end
      end
   end

   always_comb begin
      order_known_in = order_known_ff;
      this_before_in = this_before_ff;
      overlap_in     = overlap_ff;
      broken_in      = broken_ff;
      max_gap_in     = max_gap_ff;
      if (step.take) begin
         if (step.fin) begin
            order_known_in = 1'b0;
            this_before_in = 1'b0;
            overlap_in     = 1'b0;
            broken_in      = 1'b0;
            max_gap_in     = '0;
         end else begin
            order_known_in = upd_known;
            this_before_in = upd_before;
            overlap_in     = upd_overlap;
            broken_in      = upd_broken;
            max_gap_in     = upd_max;
         end
      end
   end

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = (step.take && step.fin) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         order_known_ff <= 1'b0;
         this_before_ff <= 1'b0;
         overlap_ff     <= 1'b0;
         broken_ff      <= 1'b0;
         max_gap_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         order_known_ff <= order_known_in;
         this_before_ff <= this_before_in;
         overlap_ff     <= overlap_in;
         broken_ff      <= broken_in;
         max_gap_ff     <= max_gap_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.take && step.fin) begin
         rsp_overlaps_ff   <= upd_overlap;
         rsp_consistent_ff <= !upd_broken;
         rsp_gap_ff        <= (upd_overlap || upd_broken) ? '1 : upd_max;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_overlaps         = rsp_overlaps_ff;
   assign rsp_order_consistent = rsp_consistent_ff;
   assign rsp_gap              = rsp_gap_ff;

   // a closing item always leaves a result behind
   a_fin_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      step.take && step.fin |=> rsp_valid_ff)
      else $error("closing item produced no result");

   // a closing item starts the next comparison from clean state
   a_fin_clears: assert property (@(posedge clock) disable iff (reset)
      step.take && step.fin |=> !order_known_ff && !overlap_ff && !broken_ff
                                && (max_gap_ff == '0))
      else $error("accumulators not cleared after closing item");

   // a broken order needs a first order to have been recorded
   a_broken_known: assert property (@(posedge clock) disable iff (reset)
      broken_ff |-> order_known_ff)
      else $error("order broken without known order");

   // an unsaturated distance only comes with a clean verdict
   a_gap_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_gap_ff != '1) |-> !rsp_overlaps_ff && rsp_consistent_ff)
      else $error("distance not saturated on overlap or broken order");

endmodule

### src/strand_aware_interval_set_compare_top.sv
// top level of the strand-aware interval set compare block
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    this/other first and last, final_taxon
//   rsp      out        rsp_valid/stall    overlaps, order_consistent, gap_distance
//   csr      in         csr_valid/ready    rev_comp_start
//
// one taxon is accepted every cycle while req_stall is low; a result is ready once its
// closing taxon has passed the input register, mapped register and result register
// synchronous reset clears all valid bits, the accumulators and rev_comp_start
// rsp_stall holds the result register; req_stall rises only when a closing
// taxon must wait for the result register to free up
// csr_ready is low while any taxon is still in the two pipeline stages
module strand_aware_interval_set_compare_top #(
   parameter int COORD_WIDTH = sasc_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // taxon input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sasc_pkg::FIELD_WIDTH-1:0] req_this_first,
   input  logic [sasc_pkg::FIELD_WIDTH-1:0] req_this_last,
   input  logic [sasc_pkg::FIELD_WIDTH-1:0] req_other_first,
   input  logic [sasc_pkg::FIELD_WIDTH-1:0] req_other_last,
   input  logic                             req_final_taxon,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_overlaps,
   output logic                             rsp_order_consistent,
   output logic [sasc_pkg::FIELD_WIDTH-1:0] rsp_gap_distance,
   // configuration write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sasc_pkg::FIELD_WIDTH-1:0] csr_rev_comp_start
);
   import sasc_pkg::*;

   // reverse-complement start, kept at coordinate width
   logic [COORD_WIDTH-1:0] rev_start_ff;

   // stage 1: raw input register
   logic                   s1_valid_ff, s1_valid_in;
   logic [COORD_WIDTH-1:0] s1_tf_ff, s1_tl_ff, s1_of_ff, s1_ol_ff;
   logic                   s1_fin_ff;

   // stage 2: forward-mapped intervals
   logic                   s2_valid_ff, s2_valid_in;
   logic                   s2_fin_ff, s2_shared_ff, s2_earlier_ff;
   logic [COORD_WIDTH-1:0] s2_tlo_ff, s2_thi_ff, s2_olo_ff, s2_ohi_ff;

   // mapping outputs
   logic                   t_present, o_present;
   logic [COORD_WIDTH-1:0] t_start, t_lo, t_hi;
   logic [COORD_WIDTH-1:0] o_start, o_lo, o_hi;

   logic                   req_take, s1_adv, s2_adv, out_free;
   step_type               step;
   logic [COORD_WIDTH-1:0] gap_w;

   // pipeline advance: only a closing taxon needs a free result register
   assign s2_adv    = s2_valid_ff && (!s2_fin_ff || out_free);
   assign s1_adv    = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in = req_take || (s1_valid_ff && !s1_adv);
   assign s2_valid_in = s1_adv || (s2_valid_ff && !s2_adv);

   // config only lands while nothing is in flight
   assign csr_ready = !s1_valid_ff && !s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rev_start_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (csr_valid && csr_ready) begin
            rev_start_ff <= COORD_WIDTH'(csr_rev_comp_start);
         end
      end
   end

   // input register loads on every accepted transfer
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_tf_ff  <= COORD_WIDTH'(req_this_first);
         s1_tl_ff  <= COORD_WIDTH'(req_this_last);
         s1_of_ff  <= COORD_WIDTH'(req_other_first);
         s1_ol_ff  <= COORD_WIDTH'(req_other_last);
         s1_fin_ff <= req_final_taxon;
      end
   end

   sasc_fwd_map #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_map_this (
      .first     (s1_tf_ff),
      .last      (s1_tl_ff),
      .rev_start (rev_start_ff),
      .present   (t_present),
      .start     (t_start),
      .lo        (t_lo),
      .hi        (t_hi)
   );

   sasc_fwd_map #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_map_other (
      .first     (s1_of_ff),
      .last      (s1_ol_ff),
      .rev_start (rev_start_ff),
      .present   (o_present),
      .start     (o_start),
      .lo        (o_lo),
      .hi        (o_hi)
   );

   // mapped register: sorted intervals plus the start order of this taxon
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_fin_ff     <= s1_fin_ff;
         s2_shared_ff  <= t_present && o_present;
         s2_earlier_ff <= (t_start < o_start);
         s2_tlo_ff     <= t_lo;
         s2_thi_ff     <= t_hi;
         s2_olo_ff     <= o_lo;
         s2_ohi_ff     <= o_hi;
      end
   end

   assign step.take         = s2_adv;
   assign step.fin          = s2_fin_ff;
   assign step.shared       = s2_shared_ff;
   assign step.this_earlier = s2_earlier_ff;

   sasc_accum #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_accum (
      .clock                (clock),
      .reset                (reset),
      .step                 (step),
      .this_lo              (s2_tlo_ff),
      .this_hi              (s2_thi_ff),
      .other_lo             (s2_olo_ff),
      .other_hi             (s2_ohi_ff),
      .rsp_stall            (rsp_stall),
      .out_free             (out_free),
      .rsp_valid            (rsp_valid),
      .rsp_overlaps         (rsp_overlaps),
      .rsp_order_consistent (rsp_order_consistent),
      .rsp_gap              (gap_w)
   );

   // saturated all-ones at coordinate width, then fitted to the port
   assign rsp_gap_distance = FIELD_WIDTH'(gap_w);

endmodule
